@@ hw/rtl/mflg_pkg.sv @@
package mflg_pkg;

    localparam int NODE_W = 6;
    localparam int CAP_W  = 62;
    localparam int FLOW_W = 63;

    // Operation codes of an input word.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_RUN = 2'd1;
    localparam logic [1:0] OP_CLR = 2'd2;

    // Status codes of a result word.
    localparam logic [1:0] ST_ADDED   = 2'd0;
    localparam logic [1:0] ST_FLOW    = 2'd1;
    localparam logic [1:0] ST_CLEARED = 2'd2;
    localparam logic [1:0] ST_SAME    = 2'd3;

    // Bottleneck start value of every augmenting path (2^61).
    localparam logic [CAP_W-1:0] PATH_LIMIT = 62'h2000_0000_0000_0000;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_ADD_RD, S_ADD_WR,
        S_BFS_INIT, S_BFS_POP, S_BFS_U, S_BFS_LV, S_BFS_RD, S_BFS_CHK, S_BFS_END,
        S_DFS_START, S_DFS_TOP, S_DFS_NC, S_DFS_SCAN, S_DFS_CHK, S_DFS_DEAD,
        S_DFS_POPD, S_DFS_INC,
        S_AUG_RD, S_AUG_R1, S_AUG_W1, S_AUG_W2, S_RESULT
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_CLR_STEP, CMD_LOAD, CMD_ADD_RD, CMD_ADD_WR,
        CMD_BFS_INIT, CMD_BFS_POP, CMD_BFS_U, CMD_BFS_LV, CMD_BFS_RD, CMD_BFS_CHK,
        CMD_DFS_START, CMD_DFS_TOP, CMD_DFS_NC, CMD_DFS_SCAN, CMD_DFS_CHK,
        CMD_DFS_DEAD, CMD_DFS_POPD, CMD_DFS_INC,
        CMD_AUG_RD, CMD_AUG_R1, CMD_AUG_W1, CMD_AUG_W2, CMD_OUT_LOAD
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [1:0] code;
    } t_ctrl;

    typedef struct packed {
        logic [1:0] op;
        logic       in_range;
        logic       same_node;
        logic       bfs_empty;
        logic       scan_last;
        logic       scan_end;
        logic       sink_live;
        logic       edge_ok;
        logic       at_sink;
        logic       depth_zero;
        logic       k_last;
        logic       clr_last;
        logic       out_busy;
    } t_dp_stat;

    // Saturating add of two capacities.
    function automatic logic [FLOW_W-1:0] sat_add(input logic [FLOW_W-1:0] a,
                                                  input logic [FLOW_W-1:0] b);
        logic [FLOW_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[FLOW_W] ? {FLOW_W{1'b1}} : s[FLOW_W-1:0];
    endfunction

endpackage

@@ hw/rtl/mflg_ctrl.sv @@
module mflg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mflg_pkg::t_dp_stat i_stat,
    output mflg_pkg::t_ctrl    o_ctrl
);

    mflg_pkg::t_state r_state, n_state;
    logic [1:0]       r_code, n_code;
    logic             r_clr_op, n_clr_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mflg_pkg::S_CLEAR;
            r_code   <= mflg_pkg::ST_ADDED;
            r_clr_op <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_code   <= n_code;
            r_clr_op <= n_clr_op;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_clr_op    = r_clr_op;
        o_in_ready  = 1'b0;
        o_ctrl.cmd  = mflg_pkg::CMD_NONE;
        o_ctrl.code = r_code;
        case (r_state)
            mflg_pkg::S_CLEAR: begin
                o_ctrl.cmd = mflg_pkg::CMD_CLR_STEP;
                if (i_stat.clr_last) begin
                    n_state = r_clr_op ? mflg_pkg::S_RESULT : mflg_pkg::S_IDLE;
                end
            end
            mflg_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.cmd = mflg_pkg::CMD_LOAD;
                    n_clr_op   = 1'b0;
                    n_state    = mflg_pkg::S_DECODE;
                end
            end
            mflg_pkg::S_DECODE: begin
                case (i_stat.op)
                    mflg_pkg::OP_ADD: begin
                        n_code  = mflg_pkg::ST_ADDED;
                        n_state = i_stat.in_range ? mflg_pkg::S_ADD_RD : mflg_pkg::S_RESULT;
                    end
                    mflg_pkg::OP_RUN: begin
                        if (i_stat.same_node) begin
                            n_code  = mflg_pkg::ST_SAME;
                            n_state = mflg_pkg::S_RESULT;
                        end else begin
                            n_code  = mflg_pkg::ST_FLOW;
                            n_state = i_stat.in_range ? mflg_pkg::S_BFS_INIT
                                                      : mflg_pkg::S_RESULT;
                        end
                    end
                    mflg_pkg::OP_CLR: begin
                        n_code   = mflg_pkg::ST_CLEARED;
                        n_clr_op = 1'b1;
                        n_state  = mflg_pkg::S_CLEAR;
                    end
                    default: begin
                        n_code  = mflg_pkg::ST_ADDED;
                        n_state = mflg_pkg::S_RESULT;
                    end
                endcase
            end
            mflg_pkg::S_ADD_RD: begin
                o_ctrl.cmd = mflg_pkg::CMD_ADD_RD;
                n_state    = mflg_pkg::S_ADD_WR;
            end
            mflg_pkg::S_ADD_WR: begin
                o_ctrl.cmd = mflg_pkg::CMD_ADD_WR;
                n_state    = mflg_pkg::S_RESULT;
            end
            mflg_pkg::S_BFS_INIT: begin
                o_ctrl.cmd = mflg_pkg::CMD_BFS_INIT;
                n_state    = mflg_pkg::S_BFS_POP;
            end
            mflg_pkg::S_BFS_POP: begin
                if (i_stat.bfs_empty) begin
                    n_state = mflg_pkg::S_BFS_END;
                end else begin
                    o_ctrl.cmd = mflg_pkg::CMD_BFS_POP;
                    n_state    = mflg_pkg::S_BFS_U;
                end
            end
            mflg_pkg::S_BFS_U: begin
                o_ctrl.cmd = mflg_pkg::CMD_BFS_U;
                n_state    = mflg_pkg::S_BFS_LV;
            end
            mflg_pkg::S_BFS_LV: begin
                o_ctrl.cmd = mflg_pkg::CMD_BFS_LV;
                n_state    = mflg_pkg::S_BFS_RD;
            end
            mflg_pkg::S_BFS_RD: begin
                o_ctrl.cmd = mflg_pkg::CMD_BFS_RD;
                n_state    = mflg_pkg::S_BFS_CHK;
            end
            mflg_pkg::S_BFS_CHK: begin
                o_ctrl.cmd = mflg_pkg::CMD_BFS_CHK;
                n_state    = i_stat.scan_last ? mflg_pkg::S_BFS_POP : mflg_pkg::S_BFS_RD;
            end
            mflg_pkg::S_BFS_END: begin
                n_state = i_stat.sink_live ? mflg_pkg::S_DFS_START : mflg_pkg::S_RESULT;
            end
            mflg_pkg::S_DFS_START: begin
                o_ctrl.cmd = mflg_pkg::CMD_DFS_START;
                n_state    = mflg_pkg::S_DFS_TOP;
            end
            mflg_pkg::S_DFS_TOP: begin
                o_ctrl.cmd = mflg_pkg::CMD_DFS_TOP;
                n_state    = i_stat.at_sink ? mflg_pkg::S_AUG_RD : mflg_pkg::S_DFS_NC;
            end
            mflg_pkg::S_DFS_NC: begin
                o_ctrl.cmd = mflg_pkg::CMD_DFS_NC;
                n_state    = mflg_pkg::S_DFS_SCAN;
            end
            mflg_pkg::S_DFS_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = mflg_pkg::S_DFS_DEAD;
                end else begin
                    o_ctrl.cmd = mflg_pkg::CMD_DFS_SCAN;
                    n_state    = mflg_pkg::S_DFS_CHK;
                end
            end
            mflg_pkg::S_DFS_CHK: begin
                o_ctrl.cmd = mflg_pkg::CMD_DFS_CHK;
                n_state    = i_stat.edge_ok ? mflg_pkg::S_DFS_TOP : mflg_pkg::S_DFS_SCAN;
            end
            mflg_pkg::S_DFS_DEAD: begin
                o_ctrl.cmd = mflg_pkg::CMD_DFS_DEAD;
                n_state    = i_stat.depth_zero ? mflg_pkg::S_BFS_INIT : mflg_pkg::S_DFS_POPD;
            end
            mflg_pkg::S_DFS_POPD: begin
                o_ctrl.cmd = mflg_pkg::CMD_DFS_POPD;
                n_state    = mflg_pkg::S_DFS_INC;
            end
            mflg_pkg::S_DFS_INC: begin
                o_ctrl.cmd = mflg_pkg::CMD_DFS_INC;
                n_state    = mflg_pkg::S_DFS_SCAN;
            end
            mflg_pkg::S_AUG_RD: begin
                o_ctrl.cmd = mflg_pkg::CMD_AUG_RD;
                n_state    = mflg_pkg::S_AUG_R1;
            end
            mflg_pkg::S_AUG_R1: begin
                o_ctrl.cmd = mflg_pkg::CMD_AUG_R1;
                n_state    = mflg_pkg::S_AUG_W1;
            end
            mflg_pkg::S_AUG_W1: begin
                o_ctrl.cmd = mflg_pkg::CMD_AUG_W1;
                n_state    = mflg_pkg::S_AUG_W2;
            end
            mflg_pkg::S_AUG_W2: begin
                o_ctrl.cmd = mflg_pkg::CMD_AUG_W2;
                n_state    = i_stat.k_last ? mflg_pkg::S_DFS_START : mflg_pkg::S_AUG_RD;
            end
            mflg_pkg::S_RESULT: begin
                if (!i_stat.out_busy) begin
                    o_ctrl.cmd = mflg_pkg::CMD_OUT_LOAD;
                    n_state    = mflg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mflg_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/mflg_dp.sv @@
module mflg_dp #(
    parameter int NODE_COUNT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mflg_pkg::t_ctrl               i_ctrl,
    output mflg_pkg::t_dp_stat            o_stat,
    input  logic [1:0]                    i_op,
    input  logic [mflg_pkg::NODE_W-1:0]   i_node_a,
    input  logic [mflg_pkg::NODE_W-1:0]   i_node_b,
    input  logic [mflg_pkg::CAP_W-1:0]    i_capacity,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [mflg_pkg::FLOW_W-1:0]   o_flow_value,
    output logic [1:0]                    o_status
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int LW = NW + 1;
    localparam int AW = 2 * NW;
    localparam int MD = 1 << AW;
    localparam int FW = mflg_pkg::FLOW_W;
    localparam int CW = mflg_pkg::CAP_W;

    // Stores.
    logic [FW-1:0] r_mat [MD];
    logic [LW-1:0] r_lvl_mem [NODE_COUNT];
    logic [NW:0]   r_nc_mem [NODE_COUNT];
    logic [NW-1:0] r_q_mem [NODE_COUNT];
    logic [NW-1:0] r_sn_mem [NODE_COUNT];
    logic [CW-1:0] r_sl_mem [NODE_COUNT];

    logic [FW-1:0] r_mrd;
    logic [LW-1:0] r_lvl_rd;
    logic [NW:0]   r_nc_rd;
    logic [NW-1:0] r_q_rd;
    logic [NW-1:0] r_sn_rd;
    logic [CW-1:0] r_sl_rd;

    // Control registers.
    logic [NODE_COUNT-1:0] r_live;
    logic [AW-1:0]         r_clr;
    logic                  r_out_valid;

    // Working registers.
    logic [1:0]    r_op;
    logic [mflg_pkg::NODE_W-1:0] r_node_a, r_node_b;
    logic [CW-1:0] r_cap;
    logic [FW-1:0] r_total;
    logic [NW-1:0] r_u, r_pa, r_pb, r_d, r_k;
    logic [NW:0]   r_v, r_head, r_tail;
    logic [CW-1:0] r_lim;
    logic [LW-1:0] r_lvl;
    logic [FW-1:0] r_flow_out;
    logic [1:0]    r_status_out;

    logic [NW-1:0] src, snk, vidx;
    logic          edge_new, edge_ok;
    logic [CW-1:0] lim_min;

    logic          m_we;
    logic [AW-1:0] m_waddr, m_raddr;
    logic [FW-1:0] m_wdata;
    logic          l_we;
    logic [NW-1:0] l_waddr, l_raddr;
    logic [LW-1:0] l_wdata;
    logic          nc_we;
    logic [NW-1:0] nc_waddr, nc_raddr;
    logic [NW:0]   nc_wdata;
    logic          q_we;
    logic [NW-1:0] q_waddr, q_wdata;
    logic          s_we;
    logic [NW-1:0] s_waddr, s_raddr, s_wnode;
    logic [CW-1:0] s_wlim;

    assign src      = NW'(r_node_a);
    assign snk      = NW'(r_node_b);
    assign vidx     = r_v[NW-1:0];
    assign edge_new = !r_live[vidx] && (r_mrd != '0);
    assign edge_ok  = r_live[vidx] && (r_lvl_rd == LW'(r_d) + LW'(1)) && (r_mrd != '0);
    assign lim_min  = (r_mrd < {1'b0, r_lim}) ? r_mrd[CW-1:0] : r_lim;

    always_comb begin
        m_we = 1'b0;  m_waddr = '0;  m_raddr = '0;  m_wdata = '0;
        l_we = 1'b0;  l_waddr = '0;  l_raddr = '0;  l_wdata = '0;
        nc_we = 1'b0; nc_waddr = '0; nc_raddr = '0; nc_wdata = '0;
        q_we = 1'b0;  q_waddr = '0;  q_wdata = '0;
        s_we = 1'b0;  s_waddr = '0;  s_raddr = '0;  s_wnode = '0; s_wlim = '0;
        case (i_ctrl.cmd)
            mflg_pkg::CMD_CLR_STEP: begin
                m_we    = 1'b1;
                m_waddr = r_clr;
            end
            mflg_pkg::CMD_ADD_RD: begin
                m_raddr = {src, snk};
            end
            mflg_pkg::CMD_ADD_WR: begin
                m_we    = 1'b1;
                m_waddr = {src, snk};
                m_wdata = mflg_pkg::sat_add(r_mrd, {1'b0, r_cap});
            end
            mflg_pkg::CMD_BFS_INIT: begin
                l_we    = 1'b1;
                l_waddr = src;
                q_we    = 1'b1;
                q_wdata = src;
            end
            mflg_pkg::CMD_BFS_U: begin
                l_raddr  = r_q_rd;
                nc_we    = 1'b1;
                nc_waddr = r_q_rd;
            end
            mflg_pkg::CMD_BFS_RD: begin
                m_raddr = {r_u, vidx};
            end
            mflg_pkg::CMD_BFS_CHK: begin
                if (edge_new) begin
                    l_we    = 1'b1;
                    l_waddr = vidx;
                    l_wdata = r_lvl;
                    q_we    = 1'b1;
                    q_waddr = r_tail[NW-1:0];
                    q_wdata = vidx;
                end
            end
            mflg_pkg::CMD_DFS_START: begin
                s_we    = 1'b1;
                s_wnode = src;
                s_wlim  = mflg_pkg::PATH_LIMIT;
            end
            mflg_pkg::CMD_DFS_TOP: begin
                nc_raddr = r_u;
            end
            mflg_pkg::CMD_DFS_SCAN: begin
                m_raddr = {r_u, vidx};
                l_raddr = vidx;
            end
            mflg_pkg::CMD_DFS_CHK: begin
                if (edge_ok) begin
                    nc_we    = 1'b1;
                    nc_waddr = r_u;
                    nc_wdata = r_v;
                    s_we     = 1'b1;
                    s_waddr  = r_d + NW'(1);
                    s_wnode  = vidx;
                    s_wlim   = lim_min;
                end
            end
            mflg_pkg::CMD_DFS_DEAD: begin
                s_raddr = r_d - NW'(1);
            end
            mflg_pkg::CMD_DFS_POPD: begin
                nc_raddr = r_sn_rd;
            end
            mflg_pkg::CMD_AUG_RD: begin
                s_raddr = r_k - NW'(1);
            end
            mflg_pkg::CMD_AUG_R1: begin
                m_raddr = {r_sn_rd, r_pb};
            end
            mflg_pkg::CMD_AUG_W1: begin
                m_we    = 1'b1;
                m_waddr = {r_pa, r_pb};
                m_wdata = r_mrd - {1'b0, r_lim};
                m_raddr = {r_pb, r_pa};
            end
            mflg_pkg::CMD_AUG_W2: begin
                m_we    = 1'b1;
                m_waddr = {r_pb, r_pa};
                m_wdata = mflg_pkg::sat_add(r_mrd, {1'b0, r_lim});
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_mat[m_waddr] <= m_wdata;
        end
        r_mrd <= r_mat[m_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            r_lvl_mem[l_waddr] <= l_wdata;
        end
        r_lvl_rd <= r_lvl_mem[l_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (nc_we) begin
            r_nc_mem[nc_waddr] <= nc_wdata;
        end
        r_nc_rd <= r_nc_mem[nc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_q_mem[q_waddr] <= q_wdata;
        end
        r_q_rd <= r_q_mem[r_head[NW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_sn_mem[s_waddr] <= s_wnode;
            r_sl_mem[s_waddr] <= s_wlim;
        end
        r_sn_rd <= r_sn_mem[s_raddr];
        r_sl_rd <= r_sl_mem[s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.cmd == mflg_pkg::CMD_OUT_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_ctrl.cmd)
                mflg_pkg::CMD_CLR_STEP: begin
                    r_clr <= r_clr + AW'(1);
                end
                mflg_pkg::CMD_BFS_INIT: begin
                    r_live <= NODE_COUNT'(1) << src;
                end
                mflg_pkg::CMD_BFS_CHK: begin
                    if (edge_new) begin
                        r_live[vidx] <= 1'b1;
                    end
                end
                mflg_pkg::CMD_DFS_DEAD: begin
                    r_live[r_u] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            mflg_pkg::CMD_LOAD: begin
                r_op     <= i_op;
                r_node_a <= i_node_a;
                r_node_b <= i_node_b;
                r_cap    <= i_capacity;
                r_total  <= '0;
            end
            mflg_pkg::CMD_BFS_INIT: begin
                r_head <= '0;
                r_tail <= (NW+1)'(1);
            end
            mflg_pkg::CMD_BFS_POP: begin
                r_head <= r_head + (NW+1)'(1);
            end
            mflg_pkg::CMD_BFS_U: begin
                r_u <= r_q_rd;
                r_v <= '0;
            end
            mflg_pkg::CMD_BFS_LV: begin
                r_lvl <= r_lvl_rd + LW'(1);
            end
            mflg_pkg::CMD_BFS_CHK: begin
                if (edge_new) begin
                    r_tail <= r_tail + (NW+1)'(1);
                end
                r_v <= r_v + (NW+1)'(1);
            end
            mflg_pkg::CMD_DFS_START: begin
                r_u   <= src;
                r_lim <= mflg_pkg::PATH_LIMIT;
                r_d   <= '0;
            end
            mflg_pkg::CMD_DFS_TOP: begin
                r_k  <= r_d;
                r_pb <= r_u;
            end
            mflg_pkg::CMD_DFS_NC: begin
                r_v <= r_nc_rd;
            end
            mflg_pkg::CMD_DFS_CHK: begin
                if (edge_ok) begin
                    r_u   <= vidx;
                    r_lim <= lim_min;
                    r_d   <= r_d + NW'(1);
                end else begin
                    r_v <= r_v + (NW+1)'(1);
                end
            end
            mflg_pkg::CMD_DFS_DEAD: begin
                r_d <= r_d - NW'(1);
            end
            mflg_pkg::CMD_DFS_POPD: begin
                r_u   <= r_sn_rd;
                r_lim <= r_sl_rd;
            end
            mflg_pkg::CMD_DFS_INC: begin
                r_v <= r_nc_rd + (NW+1)'(1);
            end
            mflg_pkg::CMD_AUG_R1: begin
                r_pa <= r_sn_rd;
            end
            mflg_pkg::CMD_AUG_W2: begin
                r_pb <= r_pa;
                r_k  <= r_k - NW'(1);
                if (r_k == NW'(1)) begin
                    r_total <= mflg_pkg::sat_add(r_total, {1'b0, r_lim});
                end
            end
            mflg_pkg::CMD_OUT_LOAD: begin
                r_flow_out   <= r_total;
                r_status_out <= i_ctrl.code;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.op         = r_op;
    assign o_stat.in_range   = (32'(r_node_a) < NODE_COUNT) && (32'(r_node_b) < NODE_COUNT);
    assign o_stat.same_node  = (r_node_a == r_node_b);
    assign o_stat.bfs_empty  = (r_head == r_tail);
    assign o_stat.scan_last  = (r_v == (NW+1)'(NODE_COUNT - 1));
    assign o_stat.scan_end   = (r_v == (NW+1)'(NODE_COUNT));
    assign o_stat.sink_live  = r_live[snk];
    assign o_stat.edge_ok    = edge_ok;
    assign o_stat.at_sink    = (r_u == snk);
    assign o_stat.depth_zero = (r_d == '0);
    assign o_stat.k_last     = (r_k == NW'(1));
    assign o_stat.clr_last   = &r_clr;
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_flow_value = r_flow_out;
    assign o_status     = r_status_out;

endmodule

@@ hw/rtl/max_flow_level_graph_core.sv @@
// Maximum-flow engine (Dinic's method) over a residual capacity matrix of NODE_COUNT nodes,
// held in one memory of P*P words (P is NODE_COUNT rounded up to a power of two) with one
// read and one write per cycle. Each input word yields exactly one result word. An add word
// in range reads its matrix entry and writes the saturated sum, then loads its result; the
// next word can be taken once that result is loaded. A clear word sweeps the matrix one
// entry per cycle before its result is loaded. After reset the same sweep runs while the input
// is not ready. A run word takes a time set by the graph: each breadth-first phase reads every
// matrix entry in the row of each reached node, each depth-first step reads every entry it
// scans, and each augmenting path updates both directions of every edge on it. One word is
// processed at a time; a finished result waits in the output register while the next word is
// accepted.
module max_flow_level_graph_core #(
    parameter int NODE_COUNT = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_op,
    input  logic [mflg_pkg::NODE_W-1:0] i_node_a,
    input  logic [mflg_pkg::NODE_W-1:0] i_node_b,
    input  logic [mflg_pkg::CAP_W-1:0]  i_capacity,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [mflg_pkg::FLOW_W-1:0] o_flow_value,
    output logic [1:0]                  o_status
);

    // Commands flow from the sequencer to the datapath, status flags flow back.
    mflg_pkg::t_ctrl    ctrl;
    mflg_pkg::t_dp_stat stat;

    mflg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    mflg_dp #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .i_op         (i_op),
        .i_node_a     (i_node_a),
        .i_node_b     (i_node_b),
        .i_capacity   (i_capacity),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_flow_value (o_flow_value),
        .o_status     (o_status)
    );

endmodule

@@ hw/rtl/mflg_chk.sv @@
module mflg_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [mflg_pkg::FLOW_W-1:0] o_flow_value,
    input logic [1:0]                  o_status
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_flow_value)
                                         && $stable(o_status))
        else $error("result word changed while stalled");

    // Only a flow result carries a nonzero flow value.
    a_flow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != mflg_pkg::ST_FLOW |-> o_flow_value == '0)
        else $error("nonzero flow on a non-flow result");

    // One word at a time: the input closes right after an accept.
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted on consecutive cycles");

endmodule

bind max_flow_level_graph_core mflg_chk u_mflg_chk (.*);
